>>> hw/rtl/selective_repeat_sender_window_top_macros.svh
// ----------------------------------------------------------------------------
// selective repeat sender window assertion macros
// concurrent assertion helpers used by the datapath rtl file
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_TOP_MACROS_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define SRSW_ASSERT(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define SRSW_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SRSW_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SRSW_ASSERT(name, clk, rst, expr)
`define SRSW_ASSERT_IMPL(name, clk, rst, ante, cons)
`define SRSW_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/srsw_pkg.sv
// ----------------------------------------------------------------------------
// srsw package
// widths, codes and shared types of the selective repeat sender window
// ----------------------------------------------------------------------------
package srsw_pkg;

   localparam int WINDOW_DEF = 8;
   localparam int SEQ_W      = 16;
   localparam int TIME_W     = 32;
   localparam int EST_W      = 24;
   localparam int CMD_W      = 3;
   localparam int KIND_W     = 3;
   localparam int CFG_W      = 16;
   localparam int ADDR_W     = 5;
   localparam int REG_W      = 3;
   localparam int DATA_W     = 32;

   localparam logic [CMD_W-1:0] CMD_START = 3'd0;
   localparam logic [CMD_W-1:0] CMD_TICK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ACK   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FILL  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SCAN  = 3'd4;

   localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SEND    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_RETX    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ACK_NEW = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ACK_DUP = 3'd4;
   localparam logic [KIND_W-1:0] KIND_ACK_OUT = 3'd5;

   localparam logic [REG_W-1:0] REG_TOTAL    = 3'd0;
   localparam logic [REG_W-1:0] REG_TMO_MIN  = 3'd1;
   localparam logic [REG_W-1:0] REG_TMO_MAX  = 3'd2;
   localparam logic [REG_W-1:0] REG_INIT_RTT = 3'd3;
   localparam logic [REG_W-1:0] REG_INIT_DEV = 3'd4;

   localparam logic [CFG_W-1:0] TOTAL_RST    = 16'd0;
   localparam logic [CFG_W-1:0] TMO_MIN_RST  = 16'd500;
   localparam logic [CFG_W-1:0] TMO_MAX_RST  = 16'd5000;
   localparam logic [CFG_W-1:0] INIT_RTT_RST = 16'd1000;
   localparam logic [CFG_W-1:0] INIT_DEV_RST = 16'd500;

   typedef struct packed {
      logic [CFG_W-1:0] total;
      logic [CFG_W-1:0] tmo_min;
      logic [CFG_W-1:0] tmo_max;
      logic [CFG_W-1:0] init_rtt;
      logic [CFG_W-1:0] init_dev;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic tick;
      logic load_window;
      logic ack_judge;
      logic ack_sample;
      logic ack_update;
      logic slide_step;
      logic emit_ack;
      logic emit_none;
      logic fill_step;
      logic scan_read;
      logic scan_check;
      logic flush;
   } ctl_type;

   typedef struct packed {
      logic ack_new;
      logic slide_ok;
      logic fill_ok;
      logic scan_more;
   } sts_type;

endpackage

>>> hw/rtl/selective_repeat_sender_window_top.sv
// ----------------------------------------------------------------------------
// selective repeat sender window top
// sender window engine: fill, ack, timeout scan and rtt estimation
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy low. Results come out one per
// cycle at most on the rsp_ ports for a single cycle marked by rsp_valid; the
// receiver must take them as they come. Tick gives no result. Ack goes
// through a sample and an update step for a new acknowledgement only, then
// slides the base one slot per step (at most WINDOW slots). Fill issues
// the new sequence numbers one per step. Scan reads each in-flight send
// time from the send time memory through its registered read port, a read
// step and a check step per in-flight slot. The last result of a request
// carries rsp_last.
module selective_repeat_sender_window_top import srsw_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [SEQ_W-1:0]  req_ack_seq,
   output logic              rsp_valid,
   output logic [KIND_W-1:0] rsp_kind,
   output logic [SEQ_W-1:0]  rsp_seq,
   output logic              rsp_last,
   output logic [SEQ_W-1:0]  rsp_window_base,
   output logic [CFG_W-1:0]  rsp_rto_ms,
   output logic [CFG_W-1:0]  rsp_rtt_sample_ms,
   output logic              rsp_done_res,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   cfg_type cfg;
   ctl_type ctl;
   sts_type sts;

   srsw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   srsw_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .sts         (sts),
      .busy        (busy),
      .ctl         (ctl)
   );

   srsw_dp #(
      .WINDOW (WINDOW)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .sts               (sts),
      .req_ack_seq       (req_ack_seq),
      .cfg               (cfg),
      .rsp_valid         (rsp_valid),
      .rsp_kind          (rsp_kind),
      .rsp_seq           (rsp_seq),
      .rsp_last          (rsp_last),
      .rsp_window_base   (rsp_window_base),
      .rsp_rto_ms        (rsp_rto_ms),
      .rsp_rtt_sample_ms (rsp_rtt_sample_ms),
      .rsp_done_res      (rsp_done_res)
   );

endmodule

>>> hw/rtl/srsw_ram.sv
// ----------------------------------------------------------------------------
// srsw ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module srsw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/srsw_csr.sv
// ----------------------------------------------------------------------------
// srsw csr
// apb register file holding the transfer, timeout and rtt estimator settings
// ----------------------------------------------------------------------------
module srsw_csr import srsw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type          cfg_ff;
   cfg_type          cfg_in;
   logic [REG_W-1:0] reg_idx;
   logic             wr_en;

   assign reg_idx = paddr[ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_TOTAL:    cfg_in.total    = pwdata[CFG_W-1:0];
            REG_TMO_MIN:  cfg_in.tmo_min  = pwdata[CFG_W-1:0];
            REG_TMO_MAX:  cfg_in.tmo_max  = pwdata[CFG_W-1:0];
            REG_INIT_RTT: cfg_in.init_rtt = pwdata[CFG_W-1:0];
            REG_INIT_DEV: cfg_in.init_dev = pwdata[CFG_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_TOTAL:    prdata = {16'd0, cfg_ff.total};
         REG_TMO_MIN:  prdata = {16'd0, cfg_ff.tmo_min};
         REG_TMO_MAX:  prdata = {16'd0, cfg_ff.tmo_max};
         REG_INIT_RTT: prdata = {16'd0, cfg_ff.init_rtt};
         REG_INIT_DEV: prdata = {16'd0, cfg_ff.init_dev};
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.total    <= TOTAL_RST;
         cfg_ff.tmo_min  <= TMO_MIN_RST;
         cfg_ff.tmo_max  <= TMO_MAX_RST;
         cfg_ff.init_rtt <= INIT_RTT_RST;
         cfg_ff.init_dev <= INIT_DEV_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/srsw_ctrl.sv
// ----------------------------------------------------------------------------
// srsw controller
// sequences start, tick, ack, fill and scan requests over the datapath
// ----------------------------------------------------------------------------
module srsw_ctrl import srsw_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CMD_W-1:0] req_command,
   input  sts_type          sts,
   output logic             busy,
   output ctl_type          ctl
);

   typedef enum logic [3:0] {
      S_IDLE, S_START, S_START_RSP, S_ACK_RD, S_ACK_SAMP, S_ACK_UPD,
      S_SLIDE, S_FILL, S_SCAN_RD, S_SCAN_CHK
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.capture = 1'b1;
               unique case (req_command)
                  CMD_START: state_in = S_START;
                  CMD_TICK:  ctl.tick = 1'b1;
                  CMD_ACK:   state_in = S_ACK_RD;
                  CMD_FILL:  state_in = S_FILL;
                  CMD_SCAN:  state_in = S_SCAN_RD;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_START: begin
            ctl.load_window = 1'b1;
            state_in = S_START_RSP;
         end
         S_START_RSP: begin
            ctl.emit_none = 1'b1;
            state_in = S_IDLE;
         end
         S_ACK_RD: begin
            ctl.ack_judge = 1'b1;
            state_in = sts.ack_new ? S_ACK_SAMP : S_SLIDE;
         end
         S_ACK_SAMP: begin
            ctl.ack_sample = 1'b1;
            state_in = S_ACK_UPD;
         end
         S_ACK_UPD: begin
            ctl.ack_update = 1'b1;
            state_in = S_SLIDE;
         end
         S_SLIDE: begin
            if (sts.slide_ok) begin
               ctl.slide_step = 1'b1;
            end else begin
               ctl.emit_ack = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FILL: begin
            if (sts.fill_ok) begin
               ctl.fill_step = 1'b1;
            end else begin
               ctl.flush = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SCAN_RD: begin
            if (sts.scan_more) begin
               ctl.scan_read = 1'b1;
               state_in = S_SCAN_CHK;
            end else begin
               ctl.flush = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SCAN_CHK: begin
            ctl.scan_check = 1'b1;
            state_in = S_SCAN_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

>>> hw/rtl/srsw_dp.sv
// ----------------------------------------------------------------------------
// srsw datapath
// window pointers, acked bits, send times, rtt estimator and result register
// ----------------------------------------------------------------------------
`include "selective_repeat_sender_window_top_macros.svh"
module srsw_dp import srsw_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  ctl_type           ctl,
   output sts_type           sts,
   input  logic [SEQ_W-1:0]  req_ack_seq,
   input  cfg_type           cfg,
   output logic              rsp_valid,
   output logic [KIND_W-1:0] rsp_kind,
   output logic [SEQ_W-1:0]  rsp_seq,
   output logic              rsp_last,
   output logic [SEQ_W-1:0]  rsp_window_base,
   output logic [CFG_W-1:0]  rsp_rto_ms,
   output logic [CFG_W-1:0]  rsp_rtt_sample_ms,
   output logic              rsp_done_res
);

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W  = SLOT_W + 1;
   localparam logic [CNT_W-1:0]  WIN_CNT  = CNT_W'(WINDOW);
   localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(WINDOW - 1);

   logic [TIME_W-1:0] now_ff, now_in;
   logic [SEQ_W-1:0]  base_ff, base_in, next_ff, next_in;
   logic [SLOT_W-1:0] base_slot_ff, base_slot_in, next_slot_ff, next_slot_in;
   logic [WINDOW-1:0] acked_ff, acked_in;
   logic [EST_W-1:0]  est_ff, est_in, dev_ff, dev_in;
   logic [SEQ_W-1:0]  ack_seq_ff, ack_seq_in;
   logic [KIND_W-1:0] ack_kind_ff, ack_kind_in;
   logic [CFG_W-1:0]  sample_ff, sample_in;
   logic [SEQ_W-1:0]  scan_seq_ff, scan_seq_in;
   logic [SLOT_W-1:0] scan_slot_ff, scan_slot_in;
   logic [CNT_W-1:0]  slide_cnt_ff, slide_cnt_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [KIND_W-1:0] pend_kind_ff, pend_kind_in;
   logic [SEQ_W-1:0]  pend_seq_ff, pend_seq_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [SEQ_W-1:0]  rsp_seq_ff, rsp_seq_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [SEQ_W-1:0]  rsp_base_ff, rsp_base_in;
   logic [CFG_W-1:0]  rsp_tmo_ff, rsp_tmo_in;
   logic [CFG_W-1:0]  rsp_sample_ff, rsp_sample_in;
   logic              rsp_done_ff, rsp_done_in;

   logic [SEQ_W-1:0]  ack_off;
   logic [CNT_W-1:0]  ack_sum;
   logic [SLOT_W-1:0] ack_idx;
   logic              in_window;
   logic [EST_W-1:0]  tmo_raw, tmo_lo, tmo_cl;
   logic [CFG_W-1:0]  tmo_cur;
   logic [TIME_W-1:0] ram_rdata, elapsed;
   logic [SLOT_W-1:0] ram_waddr, ram_raddr;
   logic              ram_wen;
   logic              scan_hit, push;
   logic [KIND_W-1:0] push_kind;
   logic [SEQ_W-1:0]  push_seq;
   logic [EST_W-1:0]  s8, diff;

   // slot of the acknowledged sequence number, relative to the base slot
   assign ack_off   = ack_seq_ff - base_ff;
   assign ack_sum   = {1'b0, base_slot_ff} + ack_off[CNT_W-1:0];
   assign ack_idx   = (ack_sum >= WIN_CNT) ? SLOT_W'(ack_sum - WIN_CNT)
                                          : ack_sum[SLOT_W-1:0];
   assign in_window = (ack_seq_ff >= base_ff) && (ack_seq_ff < next_ff);

   // retransmit timeout: estimate plus four deviations, clamped
   assign tmo_raw = {3'd0, est_ff[EST_W-1:3]} + dev_ff;
   assign tmo_lo  = (tmo_raw < {8'd0, cfg.tmo_min}) ? {8'd0, cfg.tmo_min} : tmo_raw;
   assign tmo_cl  = (tmo_lo > {8'd0, cfg.tmo_max}) ? {8'd0, cfg.tmo_max} : tmo_lo;
   assign tmo_cur = tmo_cl[CFG_W-1:0];

   assign elapsed  = now_ff - ram_rdata;
   assign scan_hit = !acked_ff[scan_slot_ff] && (elapsed > {16'd0, tmo_cur});
   assign s8       = {5'd0, sample_ff, 3'd0};
   assign diff     = (s8 >= est_ff) ? (s8 - est_ff) : (est_ff - s8);

   assign ram_wen   = ctl.fill_step || (ctl.scan_check && scan_hit);
   assign ram_waddr = ctl.fill_step ? next_slot_ff : scan_slot_ff;
   assign ram_raddr = ctl.scan_read ? scan_slot_ff : ack_idx;

   srsw_ram #(
      .WIDTH (TIME_W),
      .DEPTH (WINDOW)
   ) u_send_time (
      .clock   (clock),
      .wr_en   (ram_wen),
      .wr_addr (ram_waddr),
      .wr_data (now_ff),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign push      = ram_wen;
   assign push_kind = ctl.fill_step ? KIND_SEND : KIND_RETX;
   assign push_seq  = ctl.fill_step ? next_ff : scan_seq_ff;

   assign sts.ack_new   = in_window && !acked_ff[ack_idx];
   assign sts.slide_ok  = (ack_kind_ff != KIND_ACK_OUT) && acked_ff[base_slot_ff]
                          && (base_ff < cfg.total) && (slide_cnt_ff < WIN_CNT);
   assign sts.fill_ok   = ({1'b0, next_ff} < ({1'b0, base_ff} + 17'(WINDOW)))
                          && (next_ff < cfg.total);
   assign sts.scan_more = scan_seq_ff < next_ff;

   always_comb begin
      now_in       = now_ff;
      base_in      = base_ff;
      next_in      = next_ff;
      base_slot_in = base_slot_ff;
      next_slot_in = next_slot_ff;
      acked_in     = acked_ff;
      est_in       = est_ff;
      dev_in       = dev_ff;
      ack_seq_in   = ack_seq_ff;
      ack_kind_in  = ack_kind_ff;
      sample_in    = sample_ff;
      scan_seq_in  = scan_seq_ff;
      scan_slot_in = scan_slot_ff;
      slide_cnt_in = slide_cnt_ff;
      if (ctl.capture) begin
         ack_seq_in   = req_ack_seq;
         sample_in    = '0;
         scan_seq_in  = base_ff;
         scan_slot_in = base_slot_ff;
         slide_cnt_in = '0;
      end
      if (ctl.tick) begin
         now_in = now_ff + 32'd1;
      end
      if (ctl.load_window) begin
         base_in      = '0;
         next_in      = '0;
         base_slot_in = '0;
         next_slot_in = '0;
         acked_in     = '0;
         est_in       = {5'd0, cfg.init_rtt, 3'd0};
         dev_in       = {6'd0, cfg.init_dev, 2'd0};
      end
      if (ctl.ack_judge) begin
         priority if (!in_window) begin
            ack_kind_in = KIND_ACK_OUT;
         end else if (acked_ff[ack_idx]) begin
            ack_kind_in = KIND_ACK_DUP;
         end else begin
            ack_kind_in = KIND_ACK_NEW;
         end
      end
      if (ctl.ack_sample) begin
         acked_in[ack_idx] = 1'b1;
         sample_in = (|elapsed[TIME_W-1:16]) ? 16'hFFFF : elapsed[15:0];
      end
      if (ctl.ack_update) begin
         dev_in = dev_ff - {2'd0, dev_ff[EST_W-1:2]} + {3'd0, diff[EST_W-1:3]};
         est_in = est_ff - {3'd0, est_ff[EST_W-1:3]} + {8'd0, sample_ff};
      end
      if (ctl.slide_step) begin
         acked_in[base_slot_ff] = 1'b0;
         base_in      = base_ff + 16'd1;
         base_slot_in = (base_slot_ff == SLOT_TOP) ? '0 : base_slot_ff + 1'b1;
         slide_cnt_in = slide_cnt_ff + 1'b1;
      end
      if (ctl.fill_step) begin
         acked_in[next_slot_ff] = 1'b0;
         next_in      = next_ff + 16'd1;
         next_slot_in = (next_slot_ff == SLOT_TOP) ? '0 : next_slot_ff + 1'b1;
      end
      if (ctl.scan_check) begin
         scan_seq_in  = scan_seq_ff + 16'd1;
         scan_slot_in = (scan_slot_ff == SLOT_TOP) ? '0 : scan_slot_ff + 1'b1;
      end
   end

   // one result held back so the final one can carry last
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_seq_in   = pend_seq_ff;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = KIND_NONE;
      rsp_seq_in    = '0;
      rsp_last_in   = 1'b1;
      rsp_sample_in = '0;
      rsp_base_in   = base_ff;
      rsp_tmo_in    = tmo_cur;
      rsp_done_in   = base_ff >= cfg.total;
      if (ctl.capture) begin
         pend_valid_in = 1'b0;
      end
      priority if (ctl.emit_none) begin
         rsp_valid_in = 1'b1;
      end else if (ctl.emit_ack) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = ack_kind_ff;
         rsp_seq_in    = ack_seq_ff;
         rsp_sample_in = sample_ff;
      end else if (ctl.flush) begin
         rsp_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
         if (pend_valid_ff) begin
            rsp_kind_in = pend_kind_ff;
            rsp_seq_in  = pend_seq_ff;
         end
      end else if (push) begin
         rsp_valid_in  = pend_valid_ff;
         rsp_kind_in   = pend_kind_ff;
         rsp_seq_in    = pend_seq_ff;
         rsp_last_in   = 1'b0;
         pend_valid_in = 1'b1;
         pend_kind_in  = push_kind;
         pend_seq_in   = push_seq;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff        <= '0;
         base_ff       <= '0;
         next_ff       <= '0;
         base_slot_ff  <= '0;
         next_slot_ff  <= '0;
         acked_ff      <= '0;
         est_ff        <= {5'd0, INIT_RTT_RST, 3'd0};
         dev_ff        <= {6'd0, INIT_DEV_RST, 2'd0};
         scan_seq_ff   <= '0;
         scan_slot_ff  <= '0;
         slide_cnt_ff  <= '0;
         ack_kind_ff   <= KIND_ACK_OUT;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         now_ff        <= now_in;
         base_ff       <= base_in;
         next_ff       <= next_in;
         base_slot_ff  <= base_slot_in;
         next_slot_ff  <= next_slot_in;
         acked_ff      <= acked_in;
         est_ff        <= est_in;
         dev_ff        <= dev_in;
         scan_seq_ff   <= scan_seq_in;
         scan_slot_ff  <= scan_slot_in;
         slide_cnt_ff  <= slide_cnt_in;
         ack_kind_ff   <= ack_kind_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ack_seq_ff    <= ack_seq_in;
      sample_ff     <= sample_in;
      pend_kind_ff  <= pend_kind_in;
      pend_seq_ff   <= pend_seq_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_seq_ff    <= rsp_seq_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_base_ff   <= rsp_base_in;
      rsp_tmo_ff    <= rsp_tmo_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_seq           = rsp_seq_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_window_base   = rsp_base_ff;
   assign rsp_rto_ms        = rsp_tmo_ff;
   assign rsp_rtt_sample_ms = rsp_sample_ff;
   assign rsp_done_res      = rsp_done_ff;

   `SRSW_ASSERT(a_window_span, clock, reset, ({1'b0, next_ff} - {1'b0, base_ff}) <= 17'(WINDOW))
   `SRSW_ASSERT_IMPL(a_none_is_last, clock, reset, rsp_valid_ff && (rsp_kind_ff == KIND_NONE), rsp_last_ff)
   `SRSW_ASSERT_NEXT(a_fill_advances, clock, reset, ctl.fill_step, next_ff == $past(next_ff) + 16'd1)
   `SRSW_ASSERT_NEXT(a_flush_drains, clock, reset, ctl.flush, rsp_valid_ff && rsp_last_ff && !pend_valid_ff)

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// selective repeat sender window testbench
// drives start, tick, ack, fill, scan and undefined requests with random gaps,
// rewrites the transfer, timeout and rtt registers between phases and compares every
// result against a window predictor held in a small scoreboard class
// ----------------------------------------------------------------------------
module tb;
   import srsw_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIN = WINDOW_DEF;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [SEQ_W-1:0]  seq;
      logic              last;
      logic [SEQ_W-1:0]  base;
      logic [CFG_W-1:0]  tmo;
      logic [CFG_W-1:0]  sample;
      logic              done;
   } window_rsp_type;

   class window_scoreboard;
      logic [31:0] regs [5];
      logic [31:0] now_ms, base_seq, next_seq, est_x8, dev_x4;
      logic        acked [WIN];
      logic [31:0] sent_at [WIN];
      window_rsp_type pending [$];
      int          errors;

      function new();
         regs[REG_TOTAL]    = TOTAL_RST;
         regs[REG_TMO_MIN]  = TMO_MIN_RST;
         regs[REG_TMO_MAX]  = TMO_MAX_RST;
         regs[REG_INIT_RTT] = INIT_RTT_RST;
         regs[REG_INIT_DEV] = INIT_DEV_RST;
         now_ms = 0;
         errors = 0;
         foreach (sent_at[i]) sent_at[i] = 0;
         load_window();
      endfunction

      function void load_window();
         base_seq = 0;
         next_seq = 0;
         foreach (acked[i]) acked[i] = 0;
         est_x8 = regs[REG_INIT_RTT] * 8;
         dev_x4 = regs[REG_INIT_DEV] * 4;
      endfunction

      function logic [15:0] timeout_now();
         logic [31:0] t;
         t = (est_x8 >> 3) + dev_x4;
         if (t < regs[REG_TMO_MIN]) t = regs[REG_TMO_MIN];
         if (t > regs[REG_TMO_MAX]) t = regs[REG_TMO_MAX];
         return t[15:0];
      endfunction

      function void push(logic [2:0] kind, logic [31:0] seq, logic [31:0] sample);
         window_rsp_type r;
         r.kind   = kind;
         r.seq    = seq[15:0];
         r.last   = 0;
         r.base   = base_seq[15:0];
         r.tmo    = timeout_now();
         r.sample = sample[15:0];
         r.done   = base_seq >= regs[REG_TOTAL];
         pending.push_back(r);
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [SEQ_W-1:0] aseq);
         int n;
         int idx;
         logic [2:0] kind;
         logic [31:0] el, smp, s8, diff, t;
         n = 0;
         case (cmd)
            CMD_START: begin
               load_window();
               push(KIND_NONE, 0, 0);
               n = 1;
            end
            CMD_TICK: now_ms = now_ms + 1;
            CMD_ACK: begin
               smp = 0;
               if (aseq >= base_seq && aseq < next_seq) begin
                  idx = aseq % WIN;
                  if (!acked[idx]) begin
                     el = now_ms - sent_at[idx];
                     acked[idx] = 1;
                     smp = (el > 65535) ? 65535 : el;
                     s8 = smp * 8;
                     diff = (s8 >= est_x8) ? s8 - est_x8 : est_x8 - s8;
                     dev_x4 = dev_x4 - (dev_x4 >> 2) + (diff >> 3);
                     est_x8 = est_x8 - (est_x8 >> 3) + smp;
                     kind = KIND_ACK_NEW;
                  end else begin
                     kind = KIND_ACK_DUP;
                  end
                  for (int i = 0; i < WIN; i++) begin
                     if (!acked[base_seq % WIN] || base_seq >= regs[REG_TOTAL]) break;
                     acked[base_seq % WIN] = 0;
                     base_seq = base_seq + 1;
                  end
               end else begin
                  kind = KIND_ACK_OUT;
               end
               push(kind, aseq, smp);
               n = 1;
            end
            CMD_FILL: begin
               while (next_seq < base_seq + WIN && next_seq < regs[REG_TOTAL] && n < WIN) begin
                  acked[next_seq % WIN] = 0;
                  sent_at[next_seq % WIN] = now_ms;
                  push(KIND_SEND, next_seq, 0);
                  n++;
                  next_seq = next_seq + 1;
               end
               if (n == 0) begin
                  push(KIND_NONE, 0, 0);
                  n = 1;
               end
            end
            CMD_SCAN: begin
               t = timeout_now();
               for (logic [31:0] s = base_seq; s < next_seq && n < WIN; s++) begin
                  if (!acked[s % WIN] && (now_ms - sent_at[s % WIN]) > t) begin
                     sent_at[s % WIN] = now_ms;
                     push(KIND_RETX, s, 0);
                     n++;
                  end
               end
               if (n == 0) begin
                  push(KIND_NONE, 0, 0);
                  n = 1;
               end
            end
            default: ;
         endcase
         if (n > 0) pending[pending.size() - 1].last = 1;
      endfunction

      function void check_result(window_rsp_type a);
         window_rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected result kind %0d seq %0d", a.kind, a.seq);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.kind !== e.kind) begin
            $error("kind: expected %0d actual %0d", e.kind, a.kind); errors++;
         end
         if (a.seq !== e.seq) begin
            $error("seq: expected %0d actual %0d", e.seq, a.seq); errors++;
         end
         if (a.last !== e.last) begin
            $error("last: expected %0d actual %0d", e.last, a.last); errors++;
         end
         if (a.base !== e.base) begin
            $error("window_base: expected %0d actual %0d", e.base, a.base); errors++;
         end
         if (a.tmo !== e.tmo) begin
            $error("rto_ms: expected %0d actual %0d", e.tmo, a.tmo); errors++;
         end
         if (a.sample !== e.sample) begin
            $error("rtt_sample_ms: expected %0d actual %0d", e.sample, a.sample); errors++;
         end
         if (a.done !== e.done) begin
            $error("done_res: expected %0d actual %0d", e.done, a.done); errors++;
         end
      endfunction
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              start = 0;
   logic              busy;
   logic [CMD_W-1:0]  req_command = CMD_TICK;
   logic [SEQ_W-1:0]  req_ack_seq = 0;
   logic              rsp_valid;
   logic [KIND_W-1:0] rsp_kind;
   logic [SEQ_W-1:0]  rsp_seq;
   logic              rsp_last;
   logic [SEQ_W-1:0]  rsp_window_base;
   logic [CFG_W-1:0]  rsp_rto_ms;
   logic [CFG_W-1:0]  rsp_rtt_sample_ms;
   logic              rsp_done_res;
   logic              psel = 0;
   logic              penable = 0;
   logic              pwrite = 0;
   logic [ADDR_W-1:0] paddr = 0;
   logic [DATA_W-1:0] pwdata = 0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   window_scoreboard sb = new();

   selective_repeat_sender_window_top dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      window_rsp_type a;
      if (!reset && rsp_valid) begin
         a.kind   = rsp_kind;
         a.seq    = rsp_seq;
         a.last   = rsp_last;
         a.base   = rsp_window_base;
         a.tmo    = rsp_rto_ms;
         a.sample = rsp_rtt_sample_ms;
         a.done   = rsp_done_res;
         sb.check_result(a);
      end
   end

   task automatic send_request(logic [CMD_W-1:0] cmd, logic [SEQ_W-1:0] aseq, bit gaps = 1);
      int gap;
      start       <= 1;
      req_command <= cmd;
      req_ack_seq <= aseq;
      do @(posedge clock); while (busy);
      sb.note_request(cmd, aseq);
      gap = 0;
      if (gaps) begin
         case ($urandom_range(9))
            0, 1, 2: gap = $urandom_range(1, 3);
            3:       gap = $urandom_range(5, 30);
            default: gap = 0;
         endcase
      end
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(logic [REG_W-1:0] idx, logic [15:0] val);
      psel    <= 1;
      pwrite  <= 1;
      penable <= 0;
      paddr   <= ADDR_W'(idx) << 2;
      pwdata  <= {16'd0, val};
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      sb.regs[idx] = val;
      psel    <= 0;
      penable <= 0;
      pwrite  <= 0;
      @(posedge clock);
   endtask

   task automatic set_phase(logic [15:0] tot, logic [15:0] tmin, logic [15:0] tmax,
                            logic [15:0] rtt, logic [15:0] dev);
      drain();
      write_reg(REG_TOTAL, tot);
      write_reg(REG_TMO_MIN, tmin);
      write_reg(REG_TMO_MAX, tmax);
      write_reg(REG_INIT_RTT, rtt);
      write_reg(REG_INIT_DEV, dev);
      send_request(CMD_START, 16'($urandom));
   endtask

   task automatic random_phase(int count);
      logic [15:0] aseq;
      int          pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 20) begin
            send_request(CMD_FILL, 16'($urandom));
         end else if (pick < 45) begin
            repeat ($urandom_range(1, 6)) send_request(CMD_TICK, 16'($urandom));
         end else if (pick < 78) begin
            if ($urandom_range(5) == 0) aseq = 16'($urandom);
            else aseq = 16'(sb.base_seq + $urandom_range(0, WIN + 1));
            send_request(CMD_ACK, aseq);
         end else if (pick < 92) begin
            send_request(CMD_SCAN, 16'($urandom));
         end else if (pick < 95) begin
            send_request(CMD_START, 16'($urandom));
         end else begin
            send_request(CMD_W'($urandom_range(5, 7)), 16'($urandom));
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset settings: empty transfer
      send_request(CMD_START, 16'hFFFF);
      send_request(CMD_FILL, 0);
      send_request(CMD_SCAN, 0);
      send_request(CMD_ACK, 16'hFFFF);
      send_request(CMD_ACK, 0);
      send_request(3'd7, 16'hFFFF);
      send_request(3'd5, 0);

      // full window, duplicates, out of order, retransmits
      set_phase(16'd10, 16'd1, 16'd8, 16'd2, 16'd1);
      send_request(CMD_FILL, 0);
      send_request(CMD_FILL, 0);
      repeat (3) send_request(CMD_TICK, 0);
      send_request(CMD_ACK, 16'd3);
      send_request(CMD_ACK, 16'd3);
      send_request(CMD_ACK, 16'd8);
      send_request(CMD_SCAN, 0);
      repeat (20) send_request(CMD_TICK, 0, 0);
      send_request(CMD_ACK, 16'd0);
      send_request(CMD_SCAN, 0);
      send_request(CMD_ACK, 16'd1);
      send_request(CMD_ACK, 16'd2);
      send_request(CMD_FILL, 0);
      send_request(CMD_SCAN, 0);

      set_phase(16'd20, 16'd1, 16'hFFFF, 16'd3, 16'd1);
      random_phase(35);
      set_phase(16'hFFFF, 16'hFFFF, 16'd1, 16'd0, 16'd0);
      random_phase(30);
      set_phase(16'd0, 16'd1, 16'd10, 16'hFFFF, 16'hFFFF);
      random_phase(15);
      set_phase(16'($urandom_range(5, 40)), 16'd2, 16'd30,
                16'($urandom_range(0, 8)), 16'($urandom_range(0, 4)));
      random_phase(35);
      set_phase(16'($urandom_range(1, 3)), 16'($urandom_range(4, 8)), 16'hFFFF,
                16'($urandom_range(0, 3)), 16'd0);
      random_phase(25);
      set_phase(16'd30, 16'd1, 16'd6, 16'd1, 16'd1);
      random_phase(30);

      drain();
      if (sb.errors == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("tb failed");
      $finish;
   end

endmodule
